// ===== hw/rtl/bbd_pkg.sv =====
// bbd_pkg: shared types, constants and the mean helper of the bilinear demosaic block
package bbd_pkg;

   localparam int SAMPLE_BITS = 8;
   localparam int CFG_BITS    = 12;
   localparam int ROW_BITS    = 11;
   localparam int SUM_BITS    = 10;
   localparam int CSR_INDEX_BITS = 1;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_HEIGHT = 1'b1;

   localparam logic [CFG_BITS-1:0] FRAME_WIDTH_RESET  = 12'd640;
   localparam logic [CFG_BITS-1:0] FRAME_HEIGHT_RESET = 12'd480;
   localparam logic [CFG_BITS-1:0] FRAME_MIN_SIZE     = 12'd2;
   localparam logic [CFG_BITS-1:0] FRAME_MAX_HEIGHT   = 12'd2048;
   localparam logic [CFG_BITS-1:0] CFG_MAX_EVEN       = {{(CFG_BITS-1){1'b1}}, 1'b0};

   // x / 3 as (x * 683) >> 11, exact for x up to three full-scale samples
   localparam logic [2*SUM_BITS-1:0] THIRD_RECIP = 20'd683;
   localparam int DIV3_SHIFT = 11;

   typedef enum logic [1:0] {
      DIV_1,
      DIV_2,
      DIV_3,
      DIV_4
   } div_type;

   typedef struct packed {
      logic [SUM_BITS-1:0] sum;
      div_type             div;
   } mean_type;

   typedef struct packed {
      logic row_odd;
      logic col_odd;
      logic top;
      logic bottom;
      logic left;
      logic right;
      logic frame_end;
   } site_type;

   function automatic mean_type make_mean(logic [SUM_BITS-1:0] s, div_type d);
      mean_type m;
      m.sum = s;
      m.div = d;
      return m;
   endfunction

   function automatic logic [SAMPLE_BITS-1:0] mean_value(mean_type m);
      logic [2*SUM_BITS-1:0]  prod;
      logic [SAMPLE_BITS-1:0] q;
      prod = (2*SUM_BITS)'(m.sum) * THIRD_RECIP;
      unique case (m.div)
         DIV_1:   q = m.sum[SAMPLE_BITS-1:0];
         DIV_2:   q = m.sum[SAMPLE_BITS:1];
         DIV_3:   q = prod[DIV3_SHIFT +: SAMPLE_BITS];
         DIV_4:   q = m.sum[SAMPLE_BITS+1:2];
         default: q = m.sum[SAMPLE_BITS-1:0];
      endcase
      return q;
   endfunction

endpackage

// ===== hw/rtl/bbd_line_store.sv =====
// bbd_line_store: the two line stores as one synchronous memory, registered read
module bbd_line_store
   import bbd_pkg::*;
#(
   parameter int DEPTH = 2048,
   parameter int AW    = $clog2(DEPTH)
)(
   input  logic                   clock,
   input  logic                   rd_en,
   input  logic [AW-1:0]          rd_addr,
   output logic [SAMPLE_BITS-1:0] rd_upper,
   output logic [SAMPLE_BITS-1:0] rd_middle,
   input  logic                   wr_en,
   input  logic [AW-1:0]          wr_addr,
   input  logic [SAMPLE_BITS-1:0] wr_upper,
   input  logic [SAMPLE_BITS-1:0] wr_middle
);

   logic [2*SAMPLE_BITS-1:0] line_mem_ff [DEPTH];
   logic [2*SAMPLE_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         line_mem_ff[wr_addr] <= {wr_upper, wr_middle};
      end
      if (rd_en) begin
         rd_data_ff <= line_mem_ff[rd_addr];
      end
   end

   assign rd_upper  = rd_data_ff[2*SAMPLE_BITS-1:SAMPLE_BITS];
   assign rd_middle = rd_data_ff[SAMPLE_BITS-1:0];

endmodule

// ===== hw/rtl/bbd_window.sv =====
// bbd_window: 3x3 sample window and per-colour neighbour sums
module bbd_window
   import bbd_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   shift_en,
   input  logic [SAMPLE_BITS-1:0] col_upper,
   input  logic [SAMPLE_BITS-1:0] col_middle,
   input  logic [SAMPLE_BITS-1:0] col_lower,
   input  logic                   step_en,
   input  site_type               site,
   output mean_type               red_sum,
   output mean_type               green_sum,
   output mean_type               blue_sum
);

   logic [SAMPLE_BITS-1:0] win_ff [3][3];
   mean_type red_ff, green_ff, blue_ff;
   mean_type red_in, green_in, blue_in;
   logic [SUM_BITS-1:0] nw, n, ne, wv, ce, ev, sw, s, se;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
               win_ff[r][c] <= '0;
            end
         end
      end else if (shift_en) begin
         for (int r = 0; r < 3; r++) begin
            win_ff[r][0] <= win_ff[r][1];
            win_ff[r][1] <= win_ff[r][2];
         end
         win_ff[0][2] <= col_upper;
         win_ff[1][2] <= col_middle;
         win_ff[2][2] <= col_lower;
      end
   end

   always_comb begin
      nw = SUM_BITS'(win_ff[0][0]);
      n  = SUM_BITS'(win_ff[0][1]);
      ne = SUM_BITS'(win_ff[0][2]);
      wv = SUM_BITS'(win_ff[1][0]);
      ce = SUM_BITS'(win_ff[1][1]);
      ev = SUM_BITS'(win_ff[1][2]);
      sw = SUM_BITS'(win_ff[2][0]);
      s  = SUM_BITS'(win_ff[2][1]);
      se = SUM_BITS'(win_ff[2][2]);
      unique case ({site.row_odd, site.col_odd})
         2'b00: begin
            // green on red row
            green_in = make_mean(ce, DIV_1);
            blue_in  = site.top  ? make_mean(s, DIV_1)  : make_mean(n + s, DIV_2);
            red_in   = site.left ? make_mean(ev, DIV_1) : make_mean(wv + ev, DIV_2);
         end
         2'b01: begin
            red_in = make_mean(ce, DIV_1);
            if (site.right) begin
               green_in = site.top ? make_mean(wv + s, DIV_2) : make_mean(n + wv + s, DIV_3);
               blue_in  = site.top ? make_mean(sw, DIV_1)     : make_mean(nw + sw, DIV_2);
            end else begin
               green_in = site.top ? make_mean(wv + ev + s, DIV_3)
                                   : make_mean(n + s + wv + ev, DIV_4);
               blue_in  = site.top ? make_mean(sw + se, DIV_2)
                                   : make_mean(nw + ne + se + sw, DIV_4);
            end
         end
         2'b10: begin
            blue_in = make_mean(ce, DIV_1);
            if (site.left) begin
               red_in   = site.bottom ? make_mean(ne, DIV_1)     : make_mean(ne + se, DIV_2);
               green_in = site.bottom ? make_mean(n + ev, DIV_2) : make_mean(n + s + ev, DIV_3);
            end else begin
               red_in   = site.bottom ? make_mean(nw + ne, DIV_2)
                                      : make_mean(nw + ne + se + sw, DIV_4);
               green_in = site.bottom ? make_mean(wv + ev + n, DIV_3)
                                      : make_mean(n + s + wv + ev, DIV_4);
            end
         end
         2'b11: begin
            // green on blue row
            green_in = make_mean(ce, DIV_1);
            red_in   = site.bottom ? make_mean(n, DIV_1)  : make_mean(n + s, DIV_2);
            blue_in  = site.right  ? make_mean(wv, DIV_1) : make_mean(wv + ev, DIV_2);
         end
         default: begin
            green_in = make_mean(ce, DIV_1);
            red_in   = make_mean(ce, DIV_1);
            blue_in  = make_mean(ce, DIV_1);
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (step_en) begin
         red_ff   <= red_in;
         green_ff <= green_in;
         blue_ff  <= blue_in;
      end
   end

   assign red_sum   = red_ff;
   assign green_sum = green_ff;
   assign blue_sum  = blue_ff;

endmodule

// ===== hw/rtl/bayer_bilinear_demosaic_top.sv =====
// bayer_bilinear_demosaic_top: GRBG bilinear demosaic, line store read-modify-write pipeline
// one sample transfer per cycle unless stalled; results pass s1, window, sum and output registers
// a result comes width+1 samples or flush items after its own; any item after a frame flushes
// one line store read and one write per cycle set the rate of one item a cycle when not stalled
// sync reset clears positions, window, valid flags, presets frame sizes; line stores not cleared
module bayer_bilinear_demosaic_top
   import bbd_pkg::*;
#(
   parameter int MAX_WIDTH = 2048
)(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [SAMPLE_BITS-1:0]    req_raw_sample,
   input  logic                      req_pad,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [SAMPLE_BITS-1:0]    rsp_red,
   output logic [SAMPLE_BITS-1:0]    rsp_green,
   output logic [SAMPLE_BITS-1:0]    rsp_blue,
   output logic                      rsp_frame_end,
   input  logic                      csr_wr_en,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CFG_BITS-1:0]       csr_data
);

   localparam int AW = $clog2(MAX_WIDTH);
   localparam int PW = ((AW > CFG_BITS) ? AW : CFG_BITS) + 1;
   localparam int WIDTH_TOP_INT = (MAX_WIDTH / 2) * 2;
   localparam logic [CFG_BITS-1:0] WIDTH_TOP =
      (WIDTH_TOP_INT > int'(CFG_MAX_EVEN)) ? CFG_MAX_EVEN : CFG_BITS'(WIDTH_TOP_INT);
   localparam logic [CFG_BITS-1:0] WIDTH_RESET =
      (FRAME_WIDTH_RESET > WIDTH_TOP) ? WIDTH_TOP : FRAME_WIDTH_RESET;

   // frame size registers, held already rounded and saturated
   logic [CFG_BITS-1:0] width_ff, width_in, height_ff, height_in;
   logic [CFG_BITS-1:0] width_even, height_even;

   always_comb begin
      width_even  = {csr_data[CFG_BITS-1:1], 1'b0};
      height_even = {csr_data[CFG_BITS-1:1], 1'b0};
      priority if (width_even < FRAME_MIN_SIZE) begin
         width_in = FRAME_MIN_SIZE;
      end else if (width_even > WIDTH_TOP) begin
         width_in = WIDTH_TOP;
      end else begin
         width_in = width_even;
      end
      priority if (height_even < FRAME_MIN_SIZE) begin
         height_in = FRAME_MIN_SIZE;
      end else if (height_even > FRAME_MAX_HEIGHT) begin
         height_in = FRAME_MAX_HEIGHT;
      end else begin
         height_in = height_even;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= FRAME_HEIGHT_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_FRAME_WIDTH:  width_ff  <= width_in;
            CSR_FRAME_HEIGHT: height_ff <= height_in;
            default:          width_ff  <= width_ff;
         endcase
      end
   end

   // pipeline flow control
   logic en, out_load, accept;
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, rsp_valid_ff;

   assign out_load  = !rsp_valid_ff || !rsp_stall;
   assign en        = !s3_valid_ff || out_load;
   assign accept    = req_valid && en;
   assign req_stall = !en;

   // position tracking
   logic [AW-1:0]       in_col_ff, in_col_in, out_col_ff, out_col_in;
   logic [ROW_BITS-1:0] in_row_ff, in_row_in, out_row_ff, out_row_in;
   logic                pending_ff, pending_in;
   logic                in_col_last, in_row_last, produce;
   logic [ROW_BITS-1:0] emit_row;
   logic [AW-1:0]       emit_col, shift_col;
   logic                emit_right, emit_bottom, has_upper, has_middle;
   logic                item_shift, item_emit;
   site_type            site;

   always_comb begin
      in_col_last = (PW'(in_col_ff) + PW'(1)) >= PW'(width_ff);
      in_row_last = (CFG_BITS'(in_row_ff) + CFG_BITS'(1)) >= height_ff;
      produce     = (in_row_ff >= ROW_BITS'(2)) ||
                    ((in_row_ff == ROW_BITS'(1)) && (in_col_ff != '0));

      if (pending_ff) begin
         emit_row = out_row_ff;
         emit_col = out_col_ff;
      end else if (in_col_ff != '0) begin
         emit_row = in_row_ff - ROW_BITS'(1);
         emit_col = in_col_ff - AW'(1);
      end else begin
         emit_row = in_row_ff - ROW_BITS'(2);
         emit_col = AW'(width_ff - CFG_BITS'(1));
      end
      emit_right  = (PW'(emit_col) + PW'(1)) >= PW'(width_ff);
      emit_bottom = (CFG_BITS'(emit_row) + CFG_BITS'(1)) >= height_ff;

      site.row_odd   = emit_row[0];
      site.col_odd   = emit_col[0];
      site.top       = (emit_row == '0);
      site.bottom    = emit_bottom;
      site.left      = (emit_col == '0);
      site.right     = emit_right;
      site.frame_end = emit_bottom && emit_right;

      item_shift = pending_ff || !req_pad;
      item_emit  = pending_ff || produce;

      if (pending_ff) begin
         shift_col  = emit_right ? '0 : emit_col + AW'(1);
         has_upper  = 1'b1;
         has_middle = 1'b1;
      end else begin
         shift_col  = in_col_ff;
         has_upper  = (in_row_ff >= ROW_BITS'(2));
         has_middle = (in_row_ff != '0);
      end

      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      pending_in = pending_ff;

      if (accept && item_shift) begin
         if (!pending_ff) begin
            priority if (in_row_last && in_col_last) begin
               in_row_in  = '0;
               in_col_in  = '0;
               pending_in = 1'b1;
            end else if (in_col_last) begin
               in_row_in = in_row_ff + ROW_BITS'(1);
               in_col_in = '0;
            end else begin
               in_col_in = in_col_ff + AW'(1);
            end
         end
         if (pending_ff && emit_bottom && emit_right) begin
            pending_in = 1'b0;
            out_row_in = '0;
            out_col_in = '0;
         end else if (item_emit) begin
            if (emit_right) begin
               out_col_in = '0;
               out_row_in = emit_row + ROW_BITS'(1);
            end else begin
               out_col_in = emit_col + AW'(1);
               out_row_in = emit_row;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
         pending_ff <= 1'b0;
      end else begin
         in_col_ff  <= in_col_in;
         in_row_ff  <= in_row_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
         pending_ff <= pending_in;
      end
   end

   // stage 1: line store data arrives, column is written back and shifted in
   logic                   s1_emit_ff, s1_has_upper_ff, s1_has_middle_ff;
   logic [AW-1:0]          s1_col_ff;
   logic [SAMPLE_BITS-1:0] s1_sample_ff;
   site_type               s1_site_ff, s2_site_ff;
   logic                   s3_frame_end_ff;
   logic [SAMPLE_BITS-1:0] rd_upper, rd_middle, col_upper, col_middle;
   logic                   wr_en;

   assign col_upper  = s1_has_upper_ff  ? rd_upper  : '0;
   assign col_middle = s1_has_middle_ff ? rd_middle : '0;
   assign wr_en      = en && s1_valid_ff;

   bbd_line_store #(
      .DEPTH (MAX_WIDTH),
      .AW    (AW)
   ) u_line_store (
      .clock     (clock),
      .rd_en     (accept),
      .rd_addr   (shift_col),
      .rd_upper  (rd_upper),
      .rd_middle (rd_middle),
      .wr_en     (wr_en),
      .wr_addr   (s1_col_ff),
      .wr_upper  (col_middle),
      .wr_middle (s1_sample_ff)
   );

   mean_type red_sum, green_sum, blue_sum;

   bbd_window u_window (
      .clock      (clock),
      .reset      (reset),
      .shift_en   (wr_en),
      .col_upper  (col_upper),
      .col_middle (col_middle),
      .col_lower  (s1_sample_ff),
      .step_en    (en),
      .site       (s2_site_ff),
      .red_sum    (red_sum),
      .green_sum  (green_sum),
      .blue_sum   (blue_sum)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (en) begin
            s1_valid_ff <= accept && item_shift;
            s2_valid_ff <= s1_valid_ff && s1_emit_ff;
            s3_valid_ff <= s2_valid_ff;
         end
         if (out_load) begin
            rsp_valid_ff <= s3_valid_ff;
         end
      end
   end

   logic [SAMPLE_BITS-1:0] rsp_red_ff, rsp_green_ff, rsp_blue_ff;
   logic                   rsp_frame_end_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         s1_emit_ff       <= item_emit;
         s1_col_ff        <= shift_col;
         s1_has_upper_ff  <= has_upper;
         s1_has_middle_ff <= has_middle;
         s1_sample_ff     <= pending_ff ? '0 : req_raw_sample;
         s1_site_ff       <= site;
         s2_site_ff       <= s1_site_ff;
         s3_frame_end_ff  <= s2_site_ff.frame_end;
      end
      if (out_load) begin
         rsp_red_ff       <= mean_value(red_sum);
         rsp_green_ff     <= mean_value(green_sum);
         rsp_blue_ff      <= mean_value(blue_sum);
         rsp_frame_end_ff <= s3_frame_end_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_red       = rsp_red_ff;
   assign rsp_green     = rsp_green_ff;
   assign rsp_blue      = rsp_blue_ff;
   assign rsp_frame_end = rsp_frame_end_ff;

endmodule

// ===== tb/bayer_bilinear_demosaic_top_test.sv =====
// bayer_bilinear_demosaic_top_test: self-checking stream testbench for the GRBG bilinear demosaic
`timescale 1ns / 100ps

module bayer_bilinear_demosaic_top_test;
   import bbd_pkg::*;

   localparam int STORE_DEPTH   = 2048;
   localparam int RANDOM_ITEMS  = 1550;
   localparam int LONG_HOLD     = 300;
   localparam int SETTLE_CYCLES = 12;
   localparam int FINAL_SPIN    = 20000;
   localparam int TIMEOUT_NS    = 8_000_000;

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] sample;
      logic                   pad;
   } mosaic_item_t;

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] red;
      logic [SAMPLE_BITS-1:0] green;
      logic [SAMPLE_BITS-1:0] blue;
      logic                   frame_end;
   } rgb_pixel_t;

   typedef enum {FILL_RANDOM, FILL_FULL, FILL_ZERO, FILL_STRIPES, FILL_EXTREMES} fill_kind_t;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic [SAMPLE_BITS-1:0]    req_raw_sample = '0;
   logic                      req_pad = 1'b0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic [SAMPLE_BITS-1:0]    rsp_red;
   logic [SAMPLE_BITS-1:0]    rsp_green;
   logic [SAMPLE_BITS-1:0]    rsp_blue;
   logic                      rsp_frame_end;
   logic                      csr_wr_en = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CFG_BITS-1:0]       csr_data = '0;

   bayer_bilinear_demosaic_top uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_raw_sample (req_raw_sample),
      .req_pad        (req_pad),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_red        (rsp_red),
      .rsp_green      (rsp_green),
      .rsp_blue       (rsp_blue),
      .rsp_frame_end  (rsp_frame_end),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   always #4 clock = ~clock;

   // predictor state
   logic [CFG_BITS-1:0]    width_reg  = FRAME_WIDTH_RESET;
   logic [CFG_BITS-1:0]    height_reg = FRAME_HEIGHT_RESET;
   logic [SAMPLE_BITS-1:0] upper_store  [STORE_DEPTH];
   logic [SAMPLE_BITS-1:0] middle_store [STORE_DEPTH];
   logic [SAMPLE_BITS-1:0] win [3][3] = '{default: '0};
   logic [ROW_BITS-1:0]    in_row  = '0;
   logic [ROW_BITS-1:0]    in_col  = '0;
   logic [ROW_BITS-1:0]    out_row = '0;
   logic [ROW_BITS-1:0]    out_col = '0;
   logic                   flushing = 1'b0;

   mosaic_item_t pending_items [$];
   rgb_pixel_t   expected_pixels [$];
   mosaic_item_t offered;
   logic         took;

   int idle_div = 0;
   int src_gap = 0;
   int sink_left = 0;
   int hold_asked = 0;
   int hold_served = 0;
   int fail_count = 0;
   int transfers_in = 0;
   int pixels_checked = 0;
   int frames_loaded = 0;
   int widest = 0;
   int narrowest = STORE_DEPTH;
   int tallest = 0;

   function automatic logic [CFG_BITS-1:0] used_width();
      logic [CFG_BITS-1:0] w;
      w = width_reg & ~12'd1;
      if (w < FRAME_MIN_SIZE) w = FRAME_MIN_SIZE;
      if (w > CFG_BITS'(STORE_DEPTH)) w = CFG_BITS'(STORE_DEPTH);
      return w;
   endfunction

   function automatic logic [CFG_BITS-1:0] used_height();
      logic [CFG_BITS-1:0] h;
      h = height_reg & ~12'd1;
      if (h < FRAME_MIN_SIZE) h = FRAME_MIN_SIZE;
      if (h > FRAME_MAX_HEIGHT) h = FRAME_MAX_HEIGHT;
      return h;
   endfunction

   function automatic void shift_column(input logic [ROW_BITS-1:0] col, input logic has_upper,
                                        input logic has_middle, input logic [SAMPLE_BITS-1:0] s);
      logic [SAMPLE_BITS-1:0] a;
      logic [SAMPLE_BITS-1:0] b;
      a = has_upper ? upper_store[col] : '0;
      b = has_middle ? middle_store[col] : '0;
      upper_store[col] = b;
      middle_store[col] = s;
      for (int k = 0; k < 3; k++) begin
         win[k][0] = win[k][1];
         win[k][1] = win[k][2];
      end
      win[0][2] = a;
      win[1][2] = b;
      win[2][2] = s;
   endfunction

   function automatic rgb_pixel_t reconstruct(input logic [ROW_BITS-1:0] r, c,
                                              input logic [CFG_BITS-1:0] w, h);
      logic [SUM_BITS-1:0] nw, n, ne, wv, ce, ev, sw, s, se;
      logic top, bottom, left, right;
      rgb_pixel_t px;
      nw = win[0][0]; n = win[0][1]; ne = win[0][2];
      wv = win[1][0]; ce = win[1][1]; ev = win[1][2];
      sw = win[2][0]; s = win[2][1]; se = win[2][2];
      top = (r == 0);
      bottom = (r + 12'd1 >= h);
      left = (c == 0);
      right = (c + 12'd1 >= w);
      if (!r[0]) begin
         if (!c[0]) begin
            px.green = ce;
            px.blue = top ? s : (n + s) / 2;
            px.red = left ? ev : (wv + ev) / 2;
         end else begin
            px.red = ce;
            if (right) begin
               px.green = top ? (wv + s) / 2 : (n + wv + s) / 3;
               px.blue = top ? sw : (nw + sw) / 2;
            end else begin
               px.green = top ? (wv + ev + s) / 3 : (n + s + wv + ev) / 4;
               px.blue = top ? (sw + se) / 2 : (nw + ne + se + sw) / 4;
            end
         end
      end else begin
         if (!c[0]) begin
            px.blue = ce;
            if (left) begin
               px.red = bottom ? ne : (ne + se) / 2;
               px.green = bottom ? (n + ev) / 2 : (n + s + ev) / 3;
            end else begin
               px.red = bottom ? (nw + ne) / 2 : (nw + ne + se + sw) / 4;
               px.green = bottom ? (wv + ev + n) / 3 : (n + s + wv + ev) / 4;
            end
         end else begin
            px.green = ce;
            px.red = bottom ? n : (n + s) / 2;
            px.blue = right ? wv : (wv + ev) / 2;
         end
      end
      px.frame_end = bottom && right;
      return px;
   endfunction

   function automatic void advance_output(input logic [ROW_BITS-1:0] r, c,
                                          input logic [CFG_BITS-1:0] w);
      if (c + 12'd1 >= w) begin
         out_col = '0;
         out_row = r + 11'd1;
      end else begin
         out_col = c + 11'd1;
         out_row = r;
      end
   endfunction

   function automatic void demosaic_step(input mosaic_item_t it);
      logic [CFG_BITS-1:0] w, h;
      logic [ROW_BITS-1:0] r, c, i, j;
      logic last_in, produce;
      w = used_width();
      h = used_height();
      if (flushing) begin
         r = out_row;
         c = out_col;
         shift_column((c + 12'd1 >= w) ? 11'd0 : c + 11'd1, 1'b1, 1'b1, '0);
         expected_pixels.push_back(reconstruct(r, c, w, h));
         if (r + 12'd1 >= h && c + 12'd1 >= w) begin
            flushing = 1'b0;
            out_row = '0;
            out_col = '0;
         end else begin
            advance_output(r, c, w);
         end
      end else if (!it.pad) begin
         i = in_row;
         j = in_col;
         shift_column(j, i >= 2, i >= 1, it.sample);
         produce = (i >= 2) || (i == 1 && j >= 1);
         last_in = (i + 12'd1 >= h) && (j + 12'd1 >= w);
         if (last_in) begin
            in_row = '0;
            in_col = '0;
         end else if (j + 12'd1 >= w) begin
            in_row = i + 11'd1;
            in_col = '0;
         end else begin
            in_col = j + 11'd1;
         end
         if (produce) begin
            if (j >= 1) begin
               r = i - 11'd1;
               c = j - 11'd1;
            end else begin
               r = i - 11'd2;
               c = ROW_BITS'(w - 12'd1);
            end
            expected_pixels.push_back(reconstruct(r, c, w, h));
            advance_output(r, c, w);
         end
         if (last_in) flushing = 1'b1;
      end
   endfunction

   function automatic void check_channel(input string name, input logic [SAMPLE_BITS-1:0] want,
                                         input logic [SAMPLE_BITS-1:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         fail_count++;
      end
   endfunction

   // sender
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         src_gap = 0;
      end else begin
         took = req_valid && !req_stall;
         if (took) begin
            demosaic_step(offered);
            transfers_in++;
         end
         if (!req_valid || took) begin
            if (src_gap != 0) begin
               src_gap--;
               req_valid <= 1'b0;
            end else if (pending_items.size() != 0) begin
               offered = pending_items.pop_front();
               req_valid <= 1'b1;
               req_raw_sample <= offered.sample;
               req_pad <= offered.pad;
               if (idle_div != 0 && $urandom_range(idle_div - 1) == 0)
                  src_gap = $urandom_range(1, 12);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         sink_left = 0;
      end else begin
         if (hold_served != hold_asked) begin
            hold_served = hold_asked;
            sink_left = LONG_HOLD;
         end else if (sink_left == 0 && idle_div != 0 && $urandom_range(idle_div - 1) == 0) begin
            sink_left = $urandom_range(1, 12);
         end
         if (sink_left != 0) begin
            rsp_stall <= 1'b1;
            sink_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // result checking
   always @(posedge clock) begin
      rgb_pixel_t want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_pixels.size() == 0) begin
            $display("%0t: unexpected transfer, expected none, actual r=%0d g=%0d b=%0d end=%0d",
                     $time, rsp_red, rsp_green, rsp_blue, rsp_frame_end);
            fail_count++;
         end else begin
            want = expected_pixels.pop_front();
            check_channel("red", want.red, rsp_red);
            check_channel("green", want.green, rsp_green);
            check_channel("blue", want.blue, rsp_blue);
            check_channel("frame_end", SAMPLE_BITS'(want.frame_end), SAMPLE_BITS'(rsp_frame_end));
            pixels_checked++;
         end
      end
   end

   task automatic write_csr(input logic [CSR_INDEX_BITS-1:0] index,
                            input logic [CFG_BITS-1:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      if (index == CSR_FRAME_WIDTH) width_reg = value;
      else height_reg = value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic set_frame_size(input logic [CFG_BITS-1:0] raw_w, raw_h);
      write_csr(CSR_FRAME_WIDTH, raw_w);
      write_csr(CSR_FRAME_HEIGHT, raw_h);
   endtask

   // one whole frame, with pads mixed in when pad_odds is nonzero, followed by the items that flush its tail
   task automatic load_frame(input fill_kind_t fill, input int pad_odds);
      mosaic_item_t it;
      int w, h;
      w = used_width();
      h = used_height();
      @(negedge clock);
      for (int p = 0; p < w * h; p++) begin
         if (pad_odds != 0 && $urandom_range(pad_odds - 1) == 0) begin
            it.sample = 8'($urandom);
            it.pad = 1'b1;
            pending_items.push_back(it);
         end
         it.pad = 1'b0;
         case (fill)
            FILL_FULL:     it.sample = 8'hFF;
            FILL_ZERO:     it.sample = 8'h00;
            FILL_STRIPES:  it.sample = p[0] ? 8'hFF : 8'h00;
            FILL_EXTREMES: it.sample = $urandom_range(1) ? 8'hFF : 8'h00;
            default:       it.sample = 8'($urandom);
         endcase
         pending_items.push_back(it);
      end
      for (int k = 0; k <= w; k++) begin
         it.sample = 8'($urandom);
         it.pad = 1'($urandom_range(1));
         pending_items.push_back(it);
      end
      frames_loaded++;
      if (w > widest) widest = w;
      if (w < narrowest) narrowest = w;
      if (h > tallest) tallest = h;
   endtask

   task automatic settle();
      @(negedge clock);
      while (pending_items.size() != 0 || req_valid || expected_pixels.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      #(TIMEOUT_NS);
      $display("%0t: timeout, %0d transfers in, %0d results outstanding",
               $time, transfers_in, expected_pixels.size());
      $display("bayer_bilinear_demosaic_top_test NOT OK");
      $finish;
   end

   initial begin
      int random_items;
      int spin;
      int nframes;
      int idle_choices [4] = '{0, 3, 6, 12};
      fill_kind_t fill;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // smallest frame at full scale and zero, pads inside the frame, odd register values
      set_frame_size(12'd2, 12'd2);
      load_frame(FILL_FULL, 0);
      load_frame(FILL_ZERO, 2);
      settle();
      set_frame_size(12'd5, 12'd3);
      load_frame(FILL_STRIPES, 0);
      settle();

      // long receiver hold so the block backs up into its input
      set_frame_size(12'd32, 12'd8);
      idle_div = 0;
      hold_asked++;
      load_frame(FILL_RANDOM, 0);
      settle();

      // widest and tallest frames, registers beyond range
      idle_div = 8;
      set_frame_size(12'hFFF, 12'd2);
      load_frame(FILL_RANDOM, 16);
      settle();
      set_frame_size(12'd1, 12'hFFF);
      load_frame(FILL_EXTREMES, 16);
      settle();
      set_frame_size(12'd0, 12'd0);
      load_frame(FILL_RANDOM, 4);
      settle();

      random_items = 0;
      while (random_items < RANDOM_ITEMS) begin
         set_frame_size(($urandom_range(7) == 0) ? 12'($urandom_range(0, 80))
                                                 : 12'($urandom_range(0, 20)),
                        12'($urandom_range(0, 14)));
         idle_div = idle_choices[$urandom_range(3)];
         nframes = $urandom_range(1, 3);
         repeat (nframes) begin
            fill = ($urandom_range(3) == 0) ? fill_kind_t'($urandom_range(1, 4)) : FILL_RANDOM;
            load_frame(fill, 12);
            random_items += int'(used_width()) * (int'(used_height()) + 1) + 1;
         end
         settle();
      end

      // closing stretch with no idling on either side
      idle_div = 0;
      set_frame_size(12'd6, 12'd4);
      load_frame(FILL_RANDOM, 0);
      load_frame(FILL_RANDOM, 0);

      @(negedge clock);
      spin = 0;
      while (spin < FINAL_SPIN
             && (pending_items.size() != 0 || req_valid || expected_pixels.size() != 0)) begin
         @(negedge clock);
         spin++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_pixels.size() != 0) begin
         $display("%0t: %0d expected results never arrived", $time, expected_pixels.size());
         fail_count++;
      end

      $display("covered %0d input transfers, %0d pixels compared over %0d frames",
               transfers_in, pixels_checked, frames_loaded);
      $display("frame widths %0d to %0d, heights up to %0d, with pads, flushes and back-pressure",
               narrowest, widest, tallest);
      if (fail_count == 0)
         $display("bayer_bilinear_demosaic_top_test OK");
      else
         $display("bayer_bilinear_demosaic_top_test NOT OK");
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/bbd_pkg.sv
hw/rtl/bbd_line_store.sv
hw/rtl/bbd_window.sv
hw/rtl/bayer_bilinear_demosaic_top.sv
tb/bayer_bilinear_demosaic_top_test.sv
